/* design/calibrated_color_window_classifier_defines.svh */
// -----------------------------------------------------------------------------
// calibrated_color_window_classifier_defines.svh
// Assertion macros shared by the color window classifier modules.
// -----------------------------------------------------------------------------
`ifndef CALIBRATED_COLOR_WINDOW_CLASSIFIER_DEFINES_SVH
`define CALIBRATED_COLOR_WINDOW_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define CCWC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define CCWC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/ccwc_pkg.sv */
// -----------------------------------------------------------------------------
// ccwc_pkg
// Types and fixed constants of the color window classifier.
// -----------------------------------------------------------------------------
package ccwc_pkg;

   // request kinds
   localparam logic [1:0] KIND_START    = 2'd0;
   localparam logic [1:0] KIND_SAMPLE   = 2'd1;
   localparam logic [1:0] KIND_MARGIN   = 2'd2;
   localparam logic [1:0] KIND_CLASSIFY = 2'd3;

   // fixed field widths
   localparam int KIND_W   = 2;
   localparam int CLASS_W  = 2;
   localparam int LEVEL_W  = 10;
   localparam int MARGIN_W = 10;
   localparam int RESULT_W = 3;

   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd5;

   // level pairs per item: red a, blue a, red b, blue b
   localparam int NUM_PAIRS = 4;
   localparam int PAIR_RED_A  = 0;
   localparam int PAIR_BLUE_A = 1;
   localparam int PAIR_RED_B  = 2;
   localparam int PAIR_BLUE_B = 3;

   // per-lane update command, at most one bit set
   typedef struct packed {
      logic start;
      logic sample;
      logic widen;
   } lane_cmd_type;

endpackage

/* design/ccwc_lane.sv */
// -----------------------------------------------------------------------------
// ccwc_lane
// One color class: holds its min/max window per sensor and light channel,
// applies start, sample and margin updates, and tests both sensors.
// -----------------------------------------------------------------------------
`include "calibrated_color_window_classifier_defines.svh"

module ccwc_lane #(
   parameter int LEVEL_MAX = 1023,
   parameter int BND_W     = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ccwc_pkg::lane_cmd_type        cmd,
   input  logic [ccwc_pkg::MARGIN_W-1:0] margin,
   input  logic [BND_W-1:0]              level [ccwc_pkg::NUM_PAIRS],
   output logic                          match_a,
   output logic                          match_b
);
   import ccwc_pkg::*;

   localparam int SUM_W = ((BND_W > MARGIN_W) ? BND_W : MARGIN_W) + 1;

   logic [BND_W-1:0] lo_ff [NUM_PAIRS];
   logic [BND_W-1:0] lo_in [NUM_PAIRS];
   logic [BND_W-1:0] hi_ff [NUM_PAIRS];
   logic [BND_W-1:0] hi_in [NUM_PAIRS];
   logic [SUM_W-1:0] lo_ext [NUM_PAIRS];
   logic [SUM_W-1:0] hi_sum [NUM_PAIRS];
   logic [SUM_W-1:0] margin_ext;
   logic [NUM_PAIRS-1:0] in_win;

   // window update, each pair independent
   always_comb begin
      margin_ext = SUM_W'(margin);
      for (int p = 0; p < NUM_PAIRS; p++) begin
         lo_ext[p] = SUM_W'(lo_ff[p]);
         hi_sum[p] = SUM_W'(hi_ff[p]) + margin_ext;
         lo_in[p]  = lo_ff[p];
         hi_in[p]  = hi_ff[p];
         priority if (cmd.start) begin
            lo_in[p] = BND_W'(LEVEL_MAX);
            hi_in[p] = '0;
         end else if (cmd.sample) begin
            if (level[p] < lo_ff[p]) lo_in[p] = level[p];
            if (level[p] > hi_ff[p]) hi_in[p] = level[p];
         end else if (cmd.widen) begin
            lo_in[p] = (lo_ext[p] > margin_ext) ? BND_W'(lo_ext[p] - margin_ext) : '0;
            hi_in[p] = (hi_sum[p] > SUM_W'(LEVEL_MAX)) ? BND_W'(LEVEL_MAX)
                                                       : BND_W'(hi_sum[p]);
         end else begin
            lo_in[p] = lo_ff[p];
            hi_in[p] = hi_ff[p];
         end
      end
   end

   // bound registers, table resets to zero
   always_ff @(posedge clock) begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
         if (reset) begin
            lo_ff[p] <= '0;
            hi_ff[p] <= '0;
         end else begin
            lo_ff[p] <= lo_in[p];
            hi_ff[p] <= hi_in[p];
         end
      end
   end

   // inclusive containment on both ends
   always_comb begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
         in_win[p] = (level[p] >= lo_ff[p]) && (level[p] <= hi_ff[p]);
      end
   end

   assign match_a = in_win[PAIR_RED_A] & in_win[PAIR_BLUE_A];
   assign match_b = in_win[PAIR_RED_B] & in_win[PAIR_BLUE_B];

   `CCWC_ASSERT_NEXT(a_start_clears, clock, reset, cmd.start,
      (lo_ff[PAIR_RED_A] == BND_W'(LEVEL_MAX)) && (hi_ff[PAIR_BLUE_B] == '0),
      "start did not clear the class window")
   `CCWC_ASSERT_NEXT(a_sample_covered, clock, reset, cmd.sample,
      (lo_ff[PAIR_RED_A] <= $past(level[PAIR_RED_A])) &&
      (hi_ff[PAIR_RED_A] >= $past(level[PAIR_RED_A])),
      "sample not inside widened window")

endmodule

/* design/ccwc_merge.sv */
// -----------------------------------------------------------------------------
// ccwc_merge
// Priority merge of the lane matches per sensor and the result register.
// -----------------------------------------------------------------------------
`include "calibrated_color_window_classifier_defines.svh"

module ccwc_merge #(
   parameter int NUM_CLASSES = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [NUM_CLASSES-1:0]        match_a,
   input  logic [NUM_CLASSES-1:0]        match_b,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [ccwc_pkg::RESULT_W-1:0] class_a,
   output logic [ccwc_pkg::RESULT_W-1:0] class_b
);
   import ccwc_pkg::*;

   localparam int CODE_W = $clog2(NUM_CLASSES + 1);

   logic [CODE_W-1:0]   code_a;
   logic [CODE_W-1:0]   code_b;
   logic [RESULT_W-1:0] res_a;
   logic [RESULT_W-1:0] res_b;
   logic                valid_ff;
   logic                valid_in;
   logic [RESULT_W-1:0] class_a_ff;
   logic [RESULT_W-1:0] class_b_ff;

   // lowest matching class wins, else the no-match code
   always_comb begin
      code_a = CODE_W'(NUM_CLASSES);
      code_b = CODE_W'(NUM_CLASSES);
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if (match_a[i]) code_a = CODE_W'(i);
         if (match_b[i]) code_b = CODE_W'(i);
      end
   end

   assign res_a = RESULT_W'(code_a);
   assign res_b = RESULT_W'(code_b);

   // result register
   assign valid_in = load | (valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         class_a_ff <= res_a;
         class_b_ff <= res_b;
      end
   end

   assign rsp_valid = valid_ff;
   assign class_a   = class_a_ff;
   assign class_b   = class_b_ff;

   `CCWC_ASSERT_NEXT(a_load_result, clock, reset, load,
      valid_ff && (class_a_ff == $past(res_a)) && (class_b_ff == $past(res_b)),
      "loaded result not presented")

endmodule

/* design/calibrated_color_window_classifier.sv */
// -----------------------------------------------------------------------------
// calibrated_color_window_classifier
// Learns min/max color windows per class for two sensors under red and blue
// light and classifies sensor pairs against them.
//
//   channel   direction  ports
//   request   in         req_valid, req_ready, req_kind .. req_blue_level_b
//   response  out        rsp_valid, rsp_ready, rsp_class_a, rsp_class_b
//   csr       in         csr_write_en, csr_write_data (window_margin)
//
// One request per cycle. Window updates land in the class lanes at the accept
// edge; a classify result is valid the cycle after its request is accepted.
// The single result register sets the rate under backpressure: a request is
// taken while it is empty or being drained in the same cycle.
// Reset clears every window bound to zero and sets the margin to 5.
// -----------------------------------------------------------------------------
`include "calibrated_color_window_classifier_defines.svh"

module calibrated_color_window_classifier #(
   parameter int NUM_CLASSES = 4,
   parameter int LEVEL_MAX   = 1023
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ccwc_pkg::KIND_W-1:0]   req_kind,
   input  logic [ccwc_pkg::CLASS_W-1:0]  req_color_class,
   input  logic [ccwc_pkg::LEVEL_W-1:0]  req_red_level_a,
   input  logic [ccwc_pkg::LEVEL_W-1:0]  req_blue_level_a,
   input  logic [ccwc_pkg::LEVEL_W-1:0]  req_red_level_b,
   input  logic [ccwc_pkg::LEVEL_W-1:0]  req_blue_level_b,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ccwc_pkg::RESULT_W-1:0] rsp_class_a,
   output logic [ccwc_pkg::RESULT_W-1:0] rsp_class_b,
   input  logic                          csr_write_en,
   input  logic [ccwc_pkg::MARGIN_W-1:0] csr_write_data
);
   import ccwc_pkg::*;

   localparam int BND_W = $clog2(LEVEL_MAX + 1);

   logic [MARGIN_W-1:0] margin_ff;
   logic [MARGIN_W-1:0] margin_in;
   logic                accept;
   logic                load;
   logic [LEVEL_W-1:0]  raw_level [NUM_PAIRS];
   logic [BND_W-1:0]    level [NUM_PAIRS];
   lane_cmd_type        lane_cmd [NUM_CLASSES];
   logic [NUM_CLASSES-1:0] match_a;
   logic [NUM_CLASSES-1:0] match_b;

   // margin register
   assign margin_in = csr_write_en ? csr_write_data : margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
      end else begin
         margin_ff <= margin_in;
      end
   end

   // request handshake
   assign req_ready = ~rsp_valid | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign load      = accept && (req_kind == KIND_CLASSIFY);

   // clamp levels to full scale
   assign raw_level[PAIR_RED_A]  = req_red_level_a;
   assign raw_level[PAIR_BLUE_A] = req_blue_level_a;
   assign raw_level[PAIR_RED_B]  = req_red_level_b;
   assign raw_level[PAIR_BLUE_B] = req_blue_level_b;

   always_comb begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
         level[p] = (int'(raw_level[p]) > LEVEL_MAX) ? BND_W'(LEVEL_MAX)
                                                     : BND_W'(raw_level[p]);
      end
   end

   // per-lane command decode
   always_comb begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
         lane_cmd[i].start  = accept && (req_kind == KIND_START) &&
                              (int'(req_color_class) == i);
         lane_cmd[i].sample = accept && (req_kind == KIND_SAMPLE) &&
                              (int'(req_color_class) == i);
         lane_cmd[i].widen  = accept && (req_kind == KIND_MARGIN) &&
                              (int'(req_color_class) == i);
      end
   end

   // class lanes
   for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_lane
      ccwc_lane #(
         .LEVEL_MAX (LEVEL_MAX),
         .BND_W     (BND_W)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .cmd     (lane_cmd[g]),
         .margin  (margin_ff),
         .level   (level),
         .match_a (match_a[g]),
         .match_b (match_b[g])
      );
   end

   // priority merge and result register
   ccwc_merge #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .match_a   (match_a),
      .match_b   (match_b),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .class_a   (rsp_class_a),
      .class_b   (rsp_class_b)
   );

   `CCWC_ASSERT_NEXT(a_no_spurious_rsp, clock, reset,
      !load && !rsp_valid, !rsp_valid,
      "response raised without a classify request")

endmodule
